/* design/tfv_pkg.sv */
`default_nettype none

package tfv_pkg;

  // Frame layout: bytes 0..12 are held, byte 13 closes the frame.
  localparam int unsigned LAST_POS = 13;

  typedef logic [3:0] pos_t;
  typedef logic [7:0] byte_t;
  typedef byte_t [LAST_POS-1:0] frame_t;

  localparam byte_t SYNC_BYTE = 8'hFF;
  localparam byte_t END_BYTE  = 8'hFE;

  // Frame byte positions.
  localparam int unsigned POS_SYNC0 = 0;
  localparam int unsigned POS_SYNC1 = 1;
  localparam int unsigned POS_SRC   = 2;
  localparam int unsigned POS_DEST  = 5;
  localparam int unsigned POS_KIND  = 8;
  localparam int unsigned POS_P0    = 9;
  localparam int unsigned POS_P1    = 10;
  localparam int unsigned POS_P2    = 11;
  localparam int unsigned POS_P3    = 12;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_BAD_DELIM   = 2'd1,
    STATUS_BAD_TYPE    = 2'd2,
    STATUS_BAD_PAYLOAD = 2'd3
  } status_t;

  typedef logic [2:0] kind_t;

  localparam kind_t KIND_NONE  = 3'd0;
  localparam kind_t KIND_ONOFF = 3'd1;
  localparam kind_t KIND_DIMM  = 3'd2;
  localparam kind_t KIND_TIME  = 3'd3;
  localparam kind_t KIND_DATE  = 3'd4;
  localparam kind_t KIND_TEMP  = 3'd5;
  localparam kind_t KIND_VALUE = 3'd6;

  localparam byte_t DIMM_LOW_A  = 8'h08;
  localparam byte_t DIMM_LOW_B  = 8'h09;
  localparam byte_t HOUR_MAX    = 8'd23;
  localparam byte_t MINUTE_MAX  = 8'd59;
  localparam byte_t DAY_MAX     = 8'd31;
  localparam byte_t MONTH_MAX   = 8'd12;

  typedef struct packed {
    status_t      status;
    logic [23:0]  src_addr;
    logic [23:0]  dest_addr;
    kind_t        frame_kind;
    byte_t        payload_a;
    byte_t        payload_b;
    byte_t        payload_c;
  } result_t;

endpackage

`default_nettype wire

/* design/tfv_frame_capture.sv */
`default_nettype none

// Tracks the frame position and holds the first thirteen bytes of a frame.
module tfv_frame_capture (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          advance,
  input  wire tfv_pkg::byte_t data_byte,
  input  wire logic          restart,
  output tfv_pkg::frame_t    frame,
  output logic               at_end
);

  tfv_pkg::pos_t position;
  tfv_pkg::pos_t position_next;
  tfv_pkg::pos_t pos_eff;

  always_comb begin
    pos_eff = restart ? '0 : position;
    if (pos_eff > tfv_pkg::pos_t'(tfv_pkg::LAST_POS)) begin
      pos_eff = '0;
    end
    at_end = (pos_eff == tfv_pkg::pos_t'(tfv_pkg::LAST_POS));
    position_next = at_end ? '0 : pos_eff + 4'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
    end else if (advance) begin
      position <= position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && !at_end) begin
      frame[pos_eff] <= data_byte;
    end
  end

endmodule

`default_nettype wire

/* design/tfv_frame_check.sv */
`default_nettype none

// Checks a complete frame and forms the result fields.
module tfv_frame_check (
  input  wire tfv_pkg::frame_t frame,
  input  wire tfv_pkg::byte_t  end_byte,
  output tfv_pkg::result_t     result
);

  tfv_pkg::byte_t p0, p1, p2, p3, kind_byte;
  logic delim_ok;
  logic kind_ok;
  logic payload_ok;
  logic tail3_zero;

  always_comb begin
    p0        = frame[tfv_pkg::POS_P0];
    p1        = frame[tfv_pkg::POS_P1];
    p2        = frame[tfv_pkg::POS_P2];
    p3        = frame[tfv_pkg::POS_P3];
    kind_byte = frame[tfv_pkg::POS_KIND];

    delim_ok = (frame[tfv_pkg::POS_SYNC0] == tfv_pkg::SYNC_BYTE) &&
               (frame[tfv_pkg::POS_SYNC1] == tfv_pkg::SYNC_BYTE) &&
               (end_byte == tfv_pkg::END_BYTE);
    kind_ok  = (kind_byte >= 8'(tfv_pkg::KIND_ONOFF)) &&
               (kind_byte <= 8'(tfv_pkg::KIND_VALUE));
    tail3_zero = (p1 == 8'd0) && (p2 == 8'd0) && (p3 == 8'd0);

    case (kind_byte[2:0])
      tfv_pkg::KIND_ONOFF: payload_ok = (p0 <= 8'd1) && tail3_zero;
      tfv_pkg::KIND_DIMM:  payload_ok = ((p0 <= 8'd1) || (p0 == tfv_pkg::DIMM_LOW_A) ||
                                         (p0 == tfv_pkg::DIMM_LOW_B)) && tail3_zero;
      tfv_pkg::KIND_TIME:  payload_ok = (p0 <= tfv_pkg::HOUR_MAX) &&
                                        (p1 <= tfv_pkg::MINUTE_MAX) &&
                                        (p2 <= tfv_pkg::MINUTE_MAX) && (p3 == 8'd0);
      tfv_pkg::KIND_DATE:  payload_ok = (p0 >= 8'd1) && (p0 <= tfv_pkg::DAY_MAX) &&
                                        (p1 >= 8'd1) && (p1 <= tfv_pkg::MONTH_MAX) &&
                                        (p3 == 8'd0);
      tfv_pkg::KIND_TEMP:  payload_ok = (p2 <= 8'd1) && (p3 == 8'd0);
      tfv_pkg::KIND_VALUE: payload_ok = tail3_zero;
      default:             payload_ok = 1'b0;
    endcase

    result = '0;
    if (!delim_ok) begin
      result.status = tfv_pkg::STATUS_BAD_DELIM;
    end else if (!kind_ok) begin
      result.status = tfv_pkg::STATUS_BAD_TYPE;
    end else if (!payload_ok) begin
      result.status = tfv_pkg::STATUS_BAD_PAYLOAD;
    end else begin
      result.status     = tfv_pkg::STATUS_OK;
      result.src_addr   = {frame[tfv_pkg::POS_SRC+2], frame[tfv_pkg::POS_SRC+1],
                           frame[tfv_pkg::POS_SRC]};
      result.dest_addr  = {frame[tfv_pkg::POS_DEST+2], frame[tfv_pkg::POS_DEST+1],
                           frame[tfv_pkg::POS_DEST]};
      result.frame_kind = kind_byte[2:0];
      result.payload_a  = p0;
      result.payload_b  = p1;
      result.payload_c  = p2;
    end
  end

endmodule

`default_nettype wire

/* design/telemetry_frame_validator_unit.sv */
`default_nettype none

// Channel   Handshake            Payload
// input     in_valid / in_ready  data_byte, restart
// result    out_valid/ out_ready status, src_addr, dest_addr, frame_kind, payload_a/b/c
//
// One byte is accepted per cycle unless a closing byte is stalled. A byte passes
// through an input register, from which the position counter and the frame check
// act on it. A closing byte produces a result in the output register.
// Reset clears the position counter and both valid flags; held frame bytes are
// not cleared. A stalled result only holds back a closing byte in the input
// register; other bytes keep flowing while the result waits.
module telemetry_frame_validator_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        restart,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [23:0]      src_addr,
  output logic [23:0]      dest_addr,
  output logic [2:0]       frame_kind,
  output logic [7:0]       payload_a,
  output logic [7:0]       payload_b,
  output logic [7:0]       payload_c
);

  // Input register: one transaction waiting to be applied to the frame state.
  logic           in_reg_valid;
  tfv_pkg::byte_t in_reg_byte;
  logic           in_reg_restart;

  tfv_pkg::frame_t  frame;
  logic             at_end;
  tfv_pkg::result_t check_result;
  tfv_pkg::result_t result;

  logic out_free;
  logic step;

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid || out_ready;
  // A byte that does not close a frame never needs the output register.
  assign step     = in_reg_valid && (!at_end || out_free);
  assign in_ready = !in_reg_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_ready) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_reg_byte    <= data_byte;
      in_reg_restart <= restart;
    end
  end

  tfv_frame_capture u_capture (
    .clk       (clk),
    .rst       (rst),
    .advance   (step),
    .data_byte (in_reg_byte),
    .restart   (in_reg_restart),
    .frame     (frame),
    .at_end    (at_end)
  );

  // The closing byte is checked straight from the input register.
  tfv_frame_check u_check (
    .frame    (frame),
    .end_byte (in_reg_byte),
    .result   (check_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && at_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && at_end) begin
      result <= check_result;
    end
  end

  assign status     = result.status;
  assign src_addr   = result.src_addr;
  assign dest_addr  = result.dest_addr;
  assign frame_kind = result.frame_kind;
  assign payload_a  = result.payload_a;
  assign payload_b  = result.payload_b;
  assign payload_c  = result.payload_c;

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned FRAME_BYTES  = tfv_pkg::LAST_POS + 1;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        restart = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [23:0] src_addr;
  logic [23:0] dest_addr;
  logic [2:0]  frame_kind;
  logic [7:0]  payload_a;
  logic [7:0]  payload_b;
  logic [7:0]  payload_c;

  // Local copy of the framing state, advanced once per accepted transaction.
  tfv_pkg::pos_t    seen_pos = '0;
  tfv_pkg::frame_t  seen_bytes = '0;
  tfv_pkg::result_t reports_due [$];

  int errors = 0;
  int bytes_sent = 0;
  int send_idle_pct = 12;
  int recv_idle_pct = 60;
  int hold_left = 0;
  int unsigned cycles = 0;

  telemetry_frame_validator_unit DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .restart    (restart),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .src_addr   (src_addr),
    .dest_addr  (dest_addr),
    .frame_kind (frame_kind),
    .payload_a  (payload_a),
    .payload_b  (payload_b),
    .payload_c  (payload_c)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Works out the frame report, if any, that one accepted byte causes.
  task automatic predict_frame_report(input tfv_pkg::byte_t d, input logic r);
    tfv_pkg::pos_t    p;
    tfv_pkg::byte_t   kind_byte;
    tfv_pkg::byte_t   p0, p1, p2, p3;
    logic             payload_good;
    tfv_pkg::result_t rep;
    p = r ? tfv_pkg::pos_t'(0) : seen_pos;
    if (p > tfv_pkg::LAST_POS) p = '0;
    if (p < tfv_pkg::LAST_POS) begin
      seen_bytes[p] = d;
      seen_pos = p + 4'd1;
    end else begin
      seen_pos = '0;
      kind_byte = seen_bytes[tfv_pkg::POS_KIND];
      p0 = seen_bytes[tfv_pkg::POS_P0];
      p1 = seen_bytes[tfv_pkg::POS_P1];
      p2 = seen_bytes[tfv_pkg::POS_P2];
      p3 = seen_bytes[tfv_pkg::POS_P3];
      case (kind_byte)
        tfv_pkg::KIND_ONOFF: payload_good = (p0 <= 8'd1) && ({p1, p2, p3} == '0);
        tfv_pkg::KIND_DIMM: begin
          payload_good = (p0 == 8'd0 || p0 == 8'd1 || p0 == tfv_pkg::DIMM_LOW_A ||
                          p0 == tfv_pkg::DIMM_LOW_B) && ({p1, p2, p3} == '0);
        end
        tfv_pkg::KIND_TIME: begin
          payload_good = (p0 <= tfv_pkg::HOUR_MAX) && (p1 <= tfv_pkg::MINUTE_MAX)
                         && (p2 <= tfv_pkg::MINUTE_MAX) && (p3 == 8'd0);
        end
        tfv_pkg::KIND_DATE: begin
          payload_good = (p0 >= 8'd1) && (p0 <= tfv_pkg::DAY_MAX) && (p1 >= 8'd1)
                         && (p1 <= tfv_pkg::MONTH_MAX) && (p3 == 8'd0);
        end
        tfv_pkg::KIND_TEMP:  payload_good = (p2 <= 8'd1) && (p3 == 8'd0);
        tfv_pkg::KIND_VALUE: payload_good = ({p1, p2, p3} == '0);
        default:             payload_good = 1'b0;
      endcase
      // Any failed check leaves every field but the status at zero.
      rep = '0;
      if (seen_bytes[tfv_pkg::POS_SYNC0] != tfv_pkg::SYNC_BYTE ||
          seen_bytes[tfv_pkg::POS_SYNC1] != tfv_pkg::SYNC_BYTE ||
          d != tfv_pkg::END_BYTE) begin
        rep.status = tfv_pkg::STATUS_BAD_DELIM;
      end else if (kind_byte < tfv_pkg::KIND_ONOFF || kind_byte > tfv_pkg::KIND_VALUE) begin
        rep.status = tfv_pkg::STATUS_BAD_TYPE;
      end else if (!payload_good) begin
        rep.status = tfv_pkg::STATUS_BAD_PAYLOAD;
      end else begin
        rep.status     = tfv_pkg::STATUS_OK;
        rep.src_addr   = {seen_bytes[tfv_pkg::POS_SRC+2], seen_bytes[tfv_pkg::POS_SRC+1],
                          seen_bytes[tfv_pkg::POS_SRC]};
        rep.dest_addr  = {seen_bytes[tfv_pkg::POS_DEST+2], seen_bytes[tfv_pkg::POS_DEST+1],
                          seen_bytes[tfv_pkg::POS_DEST]};
        rep.frame_kind = kind_byte[2:0];
        rep.payload_a  = p0;
        rep.payload_b  = p1;
        rep.payload_c  = p2;
      end
      reports_due.push_back(rep);
    end
  endtask

  // Offers one byte, idling first at the current rate, and waits for acceptance.
  task automatic send_byte(input tfv_pkg::byte_t d, input logic r);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= d;
    restart   <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    predict_frame_report(d, r);
  endtask

  task automatic send_frame(input tfv_pkg::byte_t fb [FRAME_BYTES], input logic lead_restart,
                            input int n_bytes);
    for (int i = 0; i < n_bytes; i++) send_byte(fb[i], (i == 0) ? lead_restart : 1'b0);
  endtask

  task automatic wait_for_reports();
    in_valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // A well-formed frame most of the time, with random content and occasional
  // corruption of delimiters, type or payload, and sometimes cut short.
  task automatic send_random_frame();
    tfv_pkg::byte_t fb [FRAME_BYTES];
    int    pick;
    int    idx;
    int    cut;
    logic  lead_restart;
    fb[tfv_pkg::POS_SYNC0] = tfv_pkg::SYNC_BYTE;
    fb[tfv_pkg::POS_SYNC1] = tfv_pkg::SYNC_BYTE;
    for (int i = tfv_pkg::POS_SRC; i < tfv_pkg::POS_KIND; i++) fb[i] = tfv_pkg::byte_t'($urandom);
    fb[tfv_pkg::LAST_POS] = tfv_pkg::END_BYTE;
    pick = $urandom_range(19);
    if (pick == 0) fb[tfv_pkg::POS_KIND] = 8'd0;
    else if (pick == 1) fb[tfv_pkg::POS_KIND] = tfv_pkg::byte_t'($urandom_range(7, 255));
    else fb[tfv_pkg::POS_KIND] = tfv_pkg::byte_t'($urandom_range(1, 6));
    fb[tfv_pkg::POS_P0] = 8'd0;
    fb[tfv_pkg::POS_P1] = 8'd0;
    fb[tfv_pkg::POS_P2] = 8'd0;
    fb[tfv_pkg::POS_P3] = 8'd0;
    case (fb[tfv_pkg::POS_KIND])
      tfv_pkg::KIND_ONOFF: fb[tfv_pkg::POS_P0] = tfv_pkg::byte_t'($urandom_range(1));
      tfv_pkg::KIND_DIMM: begin
        case ($urandom_range(3))
          0:       fb[tfv_pkg::POS_P0] = 8'd0;
          1:       fb[tfv_pkg::POS_P0] = 8'd1;
          2:       fb[tfv_pkg::POS_P0] = tfv_pkg::DIMM_LOW_A;
          default: fb[tfv_pkg::POS_P0] = tfv_pkg::DIMM_LOW_B;
        endcase
      end
      tfv_pkg::KIND_TIME: begin
        fb[tfv_pkg::POS_P0] = tfv_pkg::byte_t'($urandom_range(tfv_pkg::HOUR_MAX));
        fb[tfv_pkg::POS_P1] = tfv_pkg::byte_t'($urandom_range(tfv_pkg::MINUTE_MAX));
        fb[tfv_pkg::POS_P2] = tfv_pkg::byte_t'($urandom_range(tfv_pkg::MINUTE_MAX));
      end
      tfv_pkg::KIND_DATE: begin
        fb[tfv_pkg::POS_P0] = tfv_pkg::byte_t'($urandom_range(1, tfv_pkg::DAY_MAX));
        fb[tfv_pkg::POS_P1] = tfv_pkg::byte_t'($urandom_range(1, tfv_pkg::MONTH_MAX));
        fb[tfv_pkg::POS_P2] = tfv_pkg::byte_t'($urandom);
      end
      tfv_pkg::KIND_TEMP: begin
        fb[tfv_pkg::POS_P0] = tfv_pkg::byte_t'($urandom);
        fb[tfv_pkg::POS_P1] = tfv_pkg::byte_t'($urandom);
        fb[tfv_pkg::POS_P2] = tfv_pkg::byte_t'($urandom_range(1));
      end
      tfv_pkg::KIND_VALUE: fb[tfv_pkg::POS_P0] = tfv_pkg::byte_t'($urandom);
      default: begin
        for (int i = tfv_pkg::POS_P0; i <= tfv_pkg::POS_P3; i++) begin
          fb[i] = tfv_pkg::byte_t'($urandom);
        end
      end
    endcase
    // Nudge one payload byte, often just across a range boundary.
    if ($urandom_range(99) < 35) begin
      idx = $urandom_range(tfv_pkg::POS_P0, tfv_pkg::POS_P3);
      case ($urandom_range(3))
        0:       fb[idx] = tfv_pkg::byte_t'($urandom);
        1:       fb[idx] = fb[idx] + 8'd1;
        2:       fb[idx] = fb[idx] - 8'd1;
        default: fb[idx] = 8'd0;
      endcase
    end
    if ($urandom_range(11) == 0) begin
      pick = $urandom_range(2);
      idx = (pick == 0) ? tfv_pkg::POS_SYNC0 :
            (pick == 1) ? tfv_pkg::POS_SYNC1 : tfv_pkg::LAST_POS;
      fb[idx] = tfv_pkg::byte_t'($urandom);
    end
    // Without restart the frame only lines up when the count is already at zero.
    lead_restart = (seen_pos != 0) || ($urandom_range(3) != 0);
    cut = ($urandom_range(9) == 0) ? $urandom_range(1, tfv_pkg::LAST_POS - 1) : FRAME_BYTES;
    send_frame(fb, lead_restart, cut);
  endtask

  task automatic send_noise_burst();
    int n;
    n = $urandom_range(1, 5);
    repeat (n) send_byte(tfv_pkg::byte_t'($urandom), $urandom_range(7) == 0);
  endtask

  // Right after reset the count is zero, so a frame needs no restart. Time
  // fields sit at their maxima and the addresses at both extremes.
  task automatic test_frame_after_reset();
    tfv_pkg::byte_t fb [FRAME_BYTES];
    fb = '{tfv_pkg::SYNC_BYTE, tfv_pkg::SYNC_BYTE, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00,
           tfv_pkg::byte_t'(tfv_pkg::KIND_TIME), tfv_pkg::HOUR_MAX, tfv_pkg::MINUTE_MAX,
           tfv_pkg::MINUTE_MAX, 8'h00, tfv_pkg::END_BYTE};
    send_frame(fb, 1'b0, FRAME_BYTES);
  endtask

  // A partial frame is dropped when a restart byte begins a new one.
  task automatic test_restart_mid_frame();
    tfv_pkg::byte_t fb [FRAME_BYTES];
    send_byte(tfv_pkg::SYNC_BYTE, 1'b0);
    send_byte(tfv_pkg::SYNC_BYTE, 1'b0);
    send_byte(8'hAA, 1'b0);
    fb = '{tfv_pkg::SYNC_BYTE, tfv_pkg::SYNC_BYTE, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'hFF, 8'h55,
           tfv_pkg::byte_t'(tfv_pkg::KIND_DIMM), tfv_pkg::DIMM_LOW_B, 8'h00, 8'h00, 8'h00,
           tfv_pkg::END_BYTE};
    send_frame(fb, 1'b1, FRAME_BYTES);
  endtask

  task automatic test_random_traffic(input int n_bytes, input int s_pct, input int r_pct);
    int start;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      if ($urandom_range(99) < 85) send_random_frame();
      else send_noise_burst();
    end
    wait_for_reports();
  endtask

  // The receiver stops for a long stretch while frames keep coming, so
  // reports back up and the input side has to stall.
  task automatic test_output_hold();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = HOLD_CYCLES;
    repeat (6) send_random_frame();
    wait_for_reports();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_frame_after_reset();
    test_restart_mid_frame();
    wait_for_reports();
    test_random_traffic(300, 12, 60);
    test_random_traffic(300, 60, 12);
    test_random_traffic(260, 0, 0);
    test_output_hold();
    in_valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && reports_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Receiver: random stalls, or a counted hold-off when one is requested.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic void check_field(input string name, input logic [23:0] want,
                                      input logic [23:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  initial begin
    tfv_pkg::result_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (reports_due.size() == 0) begin
          errors++;
          $display("%0t: report with none due, expected none actual status %0d",
                   $time, status);
        end else begin
          want = reports_due.pop_front();
          check_field("status", 24'(want.status), 24'(status));
          check_field("src_addr", want.src_addr, src_addr);
          check_field("dest_addr", want.dest_addr, dest_addr);
          check_field("frame_kind", 24'(want.frame_kind), 24'(frame_kind));
          check_field("payload_a", 24'(want.payload_a), 24'(payload_a));
          check_field("payload_b", 24'(want.payload_b), 24'(payload_b));
          check_field("payload_c", 24'(want.payload_c), 24'(payload_c));
        end
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

endmodule
